>>> rtl/core/k_way_timestamp_merge_unit_assert.svh
// Assertion helpers for the timestamp merge unit.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef K_WAY_TIMESTAMP_MERGE_UNIT_ASSERT_SVH
`define K_WAY_TIMESTAMP_MERGE_UNIT_ASSERT_SVH

// same-cycle implication given as one property
`define KWTM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// trigger in one cycle, condition in the next
`define KWTM_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) else $error(msg);

`endif

>>> rtl/core/kwtm_pkg.sv
package kwtm_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_RECORD = 2'd0,
    ST_DROP   = 2'd1,
    ST_DONE   = 2'd2
  } status_e;

  // classified command kinds
  typedef enum logic [1:0] {
    KIND_REC = 2'd0,
    KIND_END = 2'd1,
    KIND_NOP = 2'd2
  } kind_e;

  typedef struct packed {
    logic        [31:0] t;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } rec_t;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  stream;
    rec_t        rec;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  src;
    rec_t        rec;
  } res_t;

  localparam int          REC_W       = $bits(rec_t);
  localparam int          MAX_RESULTS = 49;
  localparam int          RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int          QDEPTH      = 2;
  localparam logic [2:0]  CFG_RST     = 3'd4;

endpackage

>>> rtl/core/kwtm_ram.sv
module kwtm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/kwtm_queue.sv
module kwtm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  kwtm_pkg::cmd_t  data_i,
  output logic            full_o,
  output logic            valid_o,
  output kwtm_pkg::cmd_t  data_o,
  input  logic            pop_i
);

  localparam int DEPTH = kwtm_pkg::QDEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  kwtm_pkg::cmd_t     entry_q [DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/kwtm_front.sv
module kwtm_front #(
  parameter int MAX_STREAMS = 4
) (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [1:0]            stream_i,
  input  logic [31:0]           time_req_i,
  input  logic signed [31:0]    pos_x_i,
  input  logic signed [31:0]    pos_y_i,
  input  logic [((($clog2(MAX_STREAMS + 1)) > 3) ? $clog2(MAX_STREAMS + 1) : 3)-1:0] nact_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output kwtm_pkg::cmd_t        cmd_o
);

  localparam int CW = ($clog2(MAX_STREAMS + 1) > 3) ? $clog2(MAX_STREAMS + 1) : 3;

  logic in_use;

  // items for streams outside the active set still trigger a merge pass
  assign in_use = (CW'(stream_i) < nact_i);

  always_comb begin
    cmd_o.stream = stream_i;
    cmd_o.rec.t  = time_req_i;
    cmd_o.rec.x  = pos_x_i;
    cmd_o.rec.y  = pos_y_i;
    if (!in_use) begin
      cmd_o.kind = kwtm_pkg::KIND_NOP;
    end else if (op_i) begin
      cmd_o.kind = kwtm_pkg::KIND_END;
    end else begin
      cmd_o.kind = kwtm_pkg::KIND_REC;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

>>> rtl/core/kwtm_back.sv
module kwtm_back #(
  parameter int MAX_STREAMS = 4,
  parameter int FIFO_DEPTH  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [((($clog2(MAX_STREAMS + 1)) > 3) ? $clog2(MAX_STREAMS + 1) : 3)-1:0] nact_i,
  input  logic                  cmd_valid_i,
  input  kwtm_pkg::cmd_t        cmd_i,
  output logic                  cmd_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [1:0]            source_o,
  output logic [31:0]           out_time_o,
  output logic signed [31:0]    out_x_o,
  output logic signed [31:0]    out_y_o,
  output logic                  last_o
);

  localparam int CW  = ($clog2(MAX_STREAMS + 1) > 3) ? $clog2(MAX_STREAMS + 1) : 3;
  localparam int SW  = $clog2(MAX_STREAMS);
  localparam int PW  = $clog2(FIFO_DEPTH);
  localparam int FW  = $clog2(FIFO_DEPTH + 1);
  localparam int AW  = SW + PW;
  localparam int NW  = kwtm_pkg::RES_CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APPLY = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [SW-1:0]          idx_q, idx_d;
  logic [NW-1:0]          n_q, n_d;
  logic                   have_q, have_d;
  logic [SW-1:0]          best_src_q, best_src_d;
  kwtm_pkg::rec_t         best_q, best_d;

  logic [FW-1:0]          fill_q [MAX_STREAMS];
  logic [FW-1:0]          fill_d [MAX_STREAMS];
  logic [PW-1:0]          rptr_q [MAX_STREAMS];
  logic [PW-1:0]          rptr_d [MAX_STREAMS];
  logic [PW-1:0]          wptr_q [MAX_STREAMS];
  logic [PW-1:0]          wptr_d [MAX_STREAMS];
  logic [MAX_STREAMS-1:0] ended_q, ended_d, empty_q, empty_d;

  logic                   pend_v_q, pend_v_d;
  kwtm_pkg::res_t         pend_q, pend_d;
  logic                   out_v_q, out_v_d;
  kwtm_pkg::res_t         out_q, out_d;
  logic                   out_last_q, out_last_d;

  logic [SW-1:0]          sel;
  logic [FW-1:0]          fill_sel;
  logic [PW-1:0]          rptr_sel, wptr_sel;
  logic                   last_idx, out_free, push_ok, finished;
  logic                   produce_en, flush_en, ram_we;
  kwtm_pkg::res_t         produce_res;
  kwtm_pkg::rec_t         rd_rec;
  logic [MAX_STREAMS-1:0] fin_vec;

  // one per-stream counter slot is looked at per cycle
  always_comb begin
    unique case (state_q)
      S_APPLY: sel = SW'(cmd_i.stream);
      S_EMIT:  sel = best_src_q;
      default: sel = idx_q;
    endcase
  end

  assign fill_sel = fill_q[sel];
  assign rptr_sel = rptr_q[sel];
  assign wptr_sel = wptr_q[sel];
  assign last_idx = (CW'(idx_q) == nact_i - CW'(1));
  assign out_free = !out_v_q || !out_stall_i;
  assign push_ok  = !pend_v_q || out_free;

  always_comb begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      fin_vec[i] = (CW'(i) >= nact_i) || (ended_q[i] && empty_q[i]);
    end
  end
  assign finished = &fin_vec;

  kwtm_ram #(
    .WIDTH (kwtm_pkg::REC_W),
    .DEPTH (MAX_STREAMS * (2 ** PW))
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'({sel, wptr_sel})),
    .wdata_i (cmd_i.rec),
    .raddr_i (AW'({sel, rptr_sel})),
    .rdata_o (rd_rec)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    n_d         = n_q;
    have_d      = have_q;
    best_src_d  = best_src_q;
    best_d      = best_q;
    fill_d      = fill_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    ended_d     = ended_q;
    empty_d     = empty_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_v_d     = out_v_q && out_stall_i;
    ram_we      = 1'b0;
    cmd_pop_o   = 1'b0;
    produce_en  = 1'b0;
    flush_en    = 1'b0;
    produce_res = pend_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          n_d     = '0;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        idx_d  = '0;
        have_d = 1'b0;
        case (cmd_i.kind)
          kwtm_pkg::KIND_REC: begin
            if (fill_sel == FW'(FIFO_DEPTH)) begin
              // buffer full: report the drop
              if (push_ok) begin
                produce_en  = 1'b1;
                produce_res = '{status: kwtm_pkg::ST_DROP, src: cmd_i.stream,
                                rec: cmd_i.rec};
                n_d         = NW'(1);
                state_d     = S_RD;
              end
            end else begin
              ram_we         = 1'b1;
              wptr_d[sel]    = (wptr_sel == PW'(FIFO_DEPTH - 1)) ? '0 : wptr_sel + PW'(1);
              fill_d[sel]    = fill_sel + FW'(1);
              empty_d[sel]   = 1'b0;
              state_d        = S_RD;
            end
          end
          kwtm_pkg::KIND_END: begin
            ended_d[sel] = 1'b1;
            state_d      = S_RD;
          end
          default: begin
            state_d = S_RD;
          end
        endcase
      end
      S_RD: begin
        if (fill_sel == '0) begin
          if (!ended_q[sel]) begin
            // a live stream has nothing buffered: stop merging
            state_d = S_FLUSH;
          end else if (last_idx) begin
            state_d = have_q ? S_EMIT : S_DONE;
          end else begin
            idx_d = idx_q + SW'(1);
          end
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (!have_q || (rd_rec.t < best_q.t)) begin
          have_d     = 1'b1;
          best_d     = rd_rec;
          best_src_d = idx_q;
        end
        if (last_idx) begin
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_q + SW'(1);
          state_d = S_RD;
        end
      end
      S_EMIT: begin
        if (push_ok) begin
          produce_en   = 1'b1;
          produce_res  = '{status: kwtm_pkg::ST_RECORD, src: 2'(best_src_q), rec: best_q};
          rptr_d[sel]  = (rptr_sel == PW'(FIFO_DEPTH - 1)) ? '0 : rptr_sel + PW'(1);
          fill_d[sel]  = fill_sel - FW'(1);
          empty_d[sel] = (fill_sel == FW'(1));
          n_d          = n_q + NW'(1);
          idx_d        = '0;
          have_d       = 1'b0;
          state_d      = (n_q + NW'(1) == NW'(kwtm_pkg::MAX_RESULTS)) ? S_FLUSH : S_RD;
        end
      end
      S_DONE: begin
        if (!finished) begin
          state_d = S_FLUSH;
        end else if (push_ok) begin
          produce_en  = 1'b1;
          produce_res = '{status: kwtm_pkg::ST_DONE, src: 2'd0, rec: '0};
          ended_d     = '0;
          n_d         = n_q + NW'(1);
          state_d     = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_v_q) begin
          cmd_pop_o = 1'b1;
          state_d   = S_IDLE;
        end else if (out_free) begin
          flush_en  = 1'b1;
          cmd_pop_o = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // one result is held back until we know whether another follows it
    if (produce_en) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_d      = pend_q;
        out_last_d = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_d   = produce_res;
    end else if (flush_en) begin
      out_v_d    = 1'b1;
      out_d      = pend_q;
      out_last_d = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      n_q      <= '0;
      have_q   <= 1'b0;
      ended_q  <= '0;
      empty_q  <= '1;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      for (int i = 0; i < MAX_STREAMS; i++) begin
        fill_q[i] <= '0;
        rptr_q[i] <= '0;
        wptr_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      n_q      <= n_d;
      have_q   <= have_d;
      ended_q  <= ended_d;
      empty_q  <= empty_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      fill_q   <= fill_d;
      rptr_q   <= rptr_d;
      wptr_q   <= wptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_src_q <= best_src_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_v_q;
  assign status_o    = out_q.status;
  assign source_o    = out_q.src;
  assign out_time_o  = out_q.rec.t;
  assign out_x_o     = out_q.rec.x;
  assign out_y_o     = out_q.rec.y;
  assign last_o      = out_last_q;

endmodule

>>> rtl/core/k_way_timestamp_merge_unit.sv
// Timestamp merge of up to MAX_STREAMS time-sorted record streams. Each input
// item for a stream in use hands a (time, x, y) record to its FIFO or marks that
// stream ended. After each item the unit emits, lowest time first (lower
// stream wins a tie), every buffered head it can while each live stream in
// use holds a head; a record hitting a full FIFO comes back as a drop result,
// and once every stream in use has ended and drained a done result follows
// and the end marks clear. One item yields at most 49 results; last_o flags
// the final one, and an item that yields none produces no output at all.
// Timing: the front end takes one item per cycle while the queue is not full,
// into a two-entry queue, so bursts of two land back to back. The back end
// then owns the item: S_IDLE picks it up and S_APPLY applies it; then, per
// merged result, S_RD skips each empty ended stream, S_RD and S_CMP take
// each buffered stream in use (registered read of the record store for each
// head compare) and S_EMIT sends the result. A final scan stops at the first
// live stream with nothing buffered, or goes to S_DONE for the done result
// once all have drained, and S_FLUSH closes out the item. The per-head scan
// of the single-read-port record store paces each merged result. One result is
// held back until the next is known, behind an output register, so a stall
// there only holds the back end once the output register and the held-back
// slot are both occupied. The user must write streams_in_use only while the
// unit is idle (not enforced); 0 acts as 1, above MAX_STREAMS as MAX_STREAMS.
// The record store needs no clearing pass: only written entries are read.
`include "k_way_timestamp_merge_unit_assert.svh"

module k_way_timestamp_merge_unit #(
  parameter int MAX_STREAMS = 4,
  parameter int FIFO_DEPTH  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_wdata_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [1:0]          stream_i,
  input  logic [31:0]         time_req_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [1:0]          source_o,
  output logic [31:0]         out_time_o,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic                last_o
);

  localparam int CW       = ($clog2(MAX_STREAMS + 1) > 3) ? $clog2(MAX_STREAMS + 1) : 3;
  localparam int NACT_RST = (int'(kwtm_pkg::CFG_RST) > MAX_STREAMS) ?
                            MAX_STREAMS : int'(kwtm_pkg::CFG_RST);

  // clamped stream count, held so both halves see the same value
  logic [CW-1:0]   nact_q, nact_d;
  logic [CW-1:0]   cfg_ext;

  logic            q_push, q_full, q_valid, q_pop;
  kwtm_pkg::cmd_t  cmd_in, cmd_head;

  assign cfg_ext = CW'(cfg_wdata_i);

  always_comb begin
    if (cfg_ext == '0) begin
      nact_d = CW'(1);
    end else if (cfg_ext > CW'(MAX_STREAMS)) begin
      nact_d = CW'(MAX_STREAMS);
    end else begin
      nact_d = cfg_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nact_q <= CW'(NACT_RST);
    end else if (cfg_we_i) begin
      nact_q <= nact_d;
    end
  end

  // classify and accept
  kwtm_front #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .stream_i   (stream_i),
    .time_req_i (time_req_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .nact_i     (nact_q),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (cmd_in)
  );

  // short decoupling queue
  kwtm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (cmd_head),
    .pop_i   (q_pop)
  );

  // buffering, merge scan and result sequencing
  kwtm_back #(
    .MAX_STREAMS (MAX_STREAMS),
    .FIFO_DEPTH  (FIFO_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nact_i      (nact_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .source_o    (source_o),
    .out_time_o  (out_time_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .last_o      (last_o)
  );

  // a done result closes its item and carries no record
  `KWTM_ASSERT(a_done_closes_item, (out_valid_o && status_o == kwtm_pkg::ST_DONE) |-> (last_o && out_time_o == 32'd0), "done result not last or not blank")
  // records and drops only come from streams in use
  `KWTM_ASSERT(a_source_in_use, (out_valid_o && status_o != kwtm_pkg::ST_DONE) |-> (CW'(source_o) < nact_q), "result from a stream not in use")
  // the queue only fills through an accepted item
  `KWTM_ASSERT_NEXT(a_stall_needs_push, !in_stall_o && !in_valid_i, !in_stall_o, "stall raised without an accepted item")

endmodule
